// File: hdl/cun_pkg.sv
// Shared types, codes and elaboration helpers for the combination unrank/next block.
`timescale 1ns / 1ps
`default_nettype none
package cun_pkg;

   // field widths fixed by the interface
   localparam int CMD_W   = 2;
   localparam int RANK_W  = 24;
   localparam int FIELD_W = 5;
   localparam int CSR_IDX_W = 1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNRANK = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SET_SIZE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CHOOSE_COUNT = 1'b1;

   // register reset values
   localparam logic [FIELD_W-1:0] SET_SIZE_RST     = 5'd24;
   localparam logic [FIELD_W-1:0] CHOOSE_COUNT_RST = 5'd1;

   // controller to datapath commands
   typedef struct packed {
      logic fill_step;
      logic accept;
      logic load_first;
      logic nx_scan;
      logic nx_fill;
      logic ur_chk_addr;
      logic ur_chk;
      logic ur_addr;
      logic ur_cmp;
      logic emit;
   } cun_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic fill_last;
      logic idx_zero;
      logic nx_hit;
      logic idx_at_k;
      logic ram_ge;
      logic j_lt_rem;
      logic ur_last;
      logic emit_last;
   } cun_stat_type;

   // bits needed for the largest entry of a dim x dim Pascal table (elaboration only)
   function automatic int binom_bits(input int dim);
      longint unsigned row [0:63];
      longint unsigned mx;
      int b;
      for (int a = 0; a < 64; a++) row[a] = 0;
      row[0] = 1;
      for (int m = 1; m < dim; m++)
         for (int c = m; c > 0; c--) row[c] = row[c] + row[c-1];
      mx = 0;
      for (int c = 0; c < dim; c++)
         if (row[c] > mx) mx = row[c];
      b = 1;
      while ((longint'(1) << b) <= mx) b++;
      return b;
   endfunction

endpackage
`default_nettype wire

// File: hdl/cun_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cun_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule
`default_nettype wire

// File: hdl/cun_datapath.sv
// Datapath: config registers, combination store, binomial table fill, unrank and next arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module cun_datapath #(
   parameter int MAX_SET   = 24,
   parameter int TABLE_DIM = 25
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cun_pkg::cun_cmd_type            cmd,
   output      cun_pkg::cun_stat_type           st,
   input  wire logic [cun_pkg::RANK_W-1:0]      req_rank,
   input  wire logic                            csr_wr_en,
   input  wire logic [cun_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cun_pkg::FIELD_W-1:0]     csr_wdata,
   output      logic                            rsp_valid,
   output      logic [cun_pkg::FIELD_W-1:0]     rsp_position,
   output      logic [cun_pkg::FIELD_W-1:0]     rsp_element,
   output      logic                            rsp_last,
   output      logic                            rsp_wrapped,
   output      logic                            rsp_rank_error
);
   import cun_pkg::*;

   localparam int LIM   = (MAX_SET < TABLE_DIM - 1) ? MAX_SET : TABLE_DIM - 1;
   localparam int EW    = $clog2(LIM + 1);
   localparam int IW    = $clog2(LIM);
   localparam int DW    = $clog2(TABLE_DIM);
   localparam int DEPTH = TABLE_DIM * TABLE_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int BW    = binom_bits(TABLE_DIM);
   localparam int CW    = (BW > RANK_W) ? BW : RANK_W;

   // config registers
   logic [FIELD_W-1:0] set_size_ff;
   logic [FIELD_W-1:0] choose_count_ff;

   // combination store, one entry per position
   logic [EW-1:0] comb_ff [0:LIM-1];

   // table fill
   logic [AW-1:0] fa_ff;
   logic [DW-1:0] fc_ff;
   logic [BW-1:0] sh_ff [0:TABLE_DIM-1];
   logic [BW-1:0] lastv_ff;
   logic [BW-1:0] fill_data;

   // command working registers
   logic [RANK_W-1:0] r_ff, r_in;
   logic [EW-1:0]     idx_ff, idx_in;
   logic [EW-1:0]     j_ff, j_in;
   logic [EW-1:0]     base_ff, base_in;
   logic [EW-1:0]     remain_ff, remain_in;
   logic [EW-1:0]     prev_ff, prev_in;
   logic [EW-1:0]     eidx_ff, eidx_in;
   logic              wrapped_ff, wrapped_in;
   logic              rerr_ff, rerr_in;

   // result registers
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_position_ff;
   logic [FIELD_W-1:0] rsp_element_ff;
   logic               rsp_last_ff;
   logic               rsp_wrapped_ff;
   logic               rsp_rank_error_ff;

   logic [5:0]    n6, k6, ns6, kc6;
   logic [EW-1:0] n_val, k_val;
   logic [EW-1:0] idx_m1;
   logic [IW-1:0] rd_i;
   logic [EW-1:0] elem_rd;
   logic [EW:0]   nx_bound;
   logic [EW-1:0] row_sel, col_sel;
   logic [AW-1:0] rd_addr;
   logic [BW-1:0] rd_data;
   logic          place_en;
   logic          load_all;

   // effective n and k, saturated
   assign ns6   = {1'b0, set_size_ff};
   assign kc6   = {1'b0, choose_count_ff};
   assign n6    = (ns6 == 6'd0) ? 6'd1 : ((ns6 > 6'(LIM)) ? 6'(LIM) : ns6);
   assign k6    = (kc6 == 6'd0) ? 6'd1 : ((kc6 > n6) ? n6 : kc6);
   assign n_val = EW'(n6);
   assign k_val = EW'(k6);

   // single read port on the combination store
   assign idx_m1  = idx_ff - EW'(1);
   assign rd_i    = cmd.emit ? eidx_ff[IW-1:0] : idx_m1[IW-1:0];
   assign elem_rd = comb_ff[rd_i];

   // successor bound n - k + position + 1
   assign nx_bound = {1'b0, n_val} - {1'b0, k_val} + {1'b0, idx_ff};

   // binomial table address: row * dim + col
   assign row_sel = cmd.ur_chk_addr ? n_val : (remain_ff - j_ff);
   assign col_sel = cmd.ur_chk_addr ? k_val : (k_val - idx_ff - EW'(1));
   assign rd_addr = AW'(row_sel) * AW'(TABLE_DIM) + AW'(col_sel);

   // Pascal row by row: new = prev[j] + prev[j-1], first column is one
   assign fill_data = (fc_ff == '0) ? BW'(1) : (sh_ff[0] + lastv_ff);

   cun_ram #(
      .WIDTH (BW),
      .DEPTH (DEPTH)
   ) u_binom (
      .clock   (clock),
      .wr_en   (cmd.fill_step),
      .wr_addr (fa_ff),
      .wr_data (fill_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // status
   always_comb begin
      st.fill_last = (fa_ff == AW'(DEPTH - 1));
      st.idx_zero  = (idx_ff == '0);
      st.nx_hit    = ({1'b0, elem_rd} < nx_bound);
      st.idx_at_k  = (idx_ff == k_val);
      st.ram_ge    = (CW'(r_ff) >= CW'(rd_data));
      st.j_lt_rem  = (j_ff < remain_ff);
      st.ur_last   = (idx_ff == k_val - EW'(1));
      st.emit_last = (eidx_ff == k_val - EW'(1));
   end

   assign place_en = (cmd.ur_addr && !st.j_lt_rem) || (cmd.ur_cmp && !st.ram_ge);
   assign load_all = csr_wr_en || cmd.load_first || (cmd.nx_scan && st.idx_zero);

   // next values of the working registers
   always_comb begin
      r_in       = r_ff;
      idx_in     = idx_ff;
      j_in       = j_ff;
      base_in    = base_ff;
      remain_in  = remain_ff;
      prev_in    = prev_ff;
      wrapped_in = wrapped_ff;
      rerr_in    = rerr_ff;
      if (cmd.accept) begin
         r_in       = req_rank;
         wrapped_in = 1'b0;
         rerr_in    = 1'b0;
         idx_in     = k_val;
      end
      if (cmd.nx_scan) begin
         if (st.idx_zero) begin
            wrapped_in = 1'b1;
         end else if (st.nx_hit) begin
            prev_in = elem_rd + EW'(1);
         end else begin
            idx_in = idx_m1;
         end
      end
      if (cmd.nx_fill) begin
         prev_in = prev_ff + EW'(1);
         idx_in  = idx_ff + EW'(1);
      end
      if (cmd.ur_chk) begin
         if (st.ram_ge) begin
            rerr_in = 1'b1;
         end else begin
            idx_in    = '0;
            j_in      = EW'(1);
            base_in   = '0;
            remain_in = n_val;
         end
      end
      if (cmd.ur_cmp && st.ram_ge) begin
         r_in = RANK_W'(CW'(r_ff) - CW'(rd_data));
         j_in = j_ff + EW'(1);
      end
      if (place_en) begin
         base_in   = base_ff + j_ff;
         remain_in = (j_ff <= remain_ff) ? (remain_ff - j_ff) : '0;
         idx_in    = idx_ff + EW'(1);
         j_in      = EW'(1);
      end
   end

   assign eidx_in = cmd.emit ? (st.emit_last ? '0 : (eidx_ff + EW'(1))) : eidx_ff;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff     <= SET_SIZE_RST;
         choose_count_ff <= CHOOSE_COUNT_RST;
         fa_ff           <= '0;
         fc_ff           <= '0;
         lastv_ff        <= '0;
         idx_ff          <= '0;
         j_ff            <= '0;
         base_ff         <= '0;
         remain_ff       <= '0;
         prev_ff         <= '0;
         eidx_ff         <= '0;
         wrapped_ff      <= 1'b0;
         rerr_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < TABLE_DIM; i++) sh_ff[i] <= '0;
         for (int i = 0; i < LIM; i++) comb_ff[i] <= EW'(i + 1);
      end else begin
         // config writes
         if (csr_wr_en) begin
            case (csr_index)
               REG_SET_SIZE:     set_size_ff     <= csr_wdata;
               REG_CHOOSE_COUNT: choose_count_ff <= csr_wdata;
               default: ;
            endcase
         end
         // table fill sweep
         if (cmd.fill_step) begin
            fa_ff    <= fa_ff + AW'(1);
            fc_ff    <= (fc_ff == DW'(TABLE_DIM - 1)) ? '0 : (fc_ff + DW'(1));
            lastv_ff <= sh_ff[0];
            for (int i = 0; i < TABLE_DIM - 1; i++) sh_ff[i] <= sh_ff[i+1];
            sh_ff[TABLE_DIM-1] <= fill_data;
         end
         // combination store updates
         if (load_all) begin
            for (int i = 0; i < LIM; i++) comb_ff[i] <= EW'(i + 1);
         end else if (cmd.nx_scan && st.nx_hit) begin
            comb_ff[idx_m1[IW-1:0]] <= prev_in;
         end else if (cmd.nx_fill) begin
            comb_ff[idx_ff[IW-1:0]] <= prev_ff + EW'(1);
         end else if (place_en) begin
            comb_ff[idx_ff[IW-1:0]] <= base_ff + j_ff;
         end
         idx_ff       <= idx_in;
         j_ff         <= j_in;
         base_ff      <= base_in;
         remain_ff    <= remain_in;
         prev_ff      <= prev_in;
         eidx_ff      <= eidx_in;
         wrapped_ff   <= wrapped_in;
         rerr_ff      <= rerr_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      r_ff <= r_in;
      if (cmd.emit) begin
         rsp_position_ff   <= FIELD_W'(eidx_ff);
         rsp_element_ff    <= FIELD_W'(elem_rd);
         rsp_last_ff       <= st.emit_last;
         rsp_wrapped_ff    <= wrapped_ff;
         rsp_rank_error_ff <= rerr_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_element    = rsp_element_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_wrapped    = rsp_wrapped_ff;
   assign rsp_rank_error = rsp_rank_error_ff;

`ifndef SYNTHESIS
   // positions of one run count up by one
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |=>
         (rsp_valid_ff && rsp_position_ff == $past(rsp_position_ff) + FIELD_W'(1)))
      else $error("position did not advance within a run");
   // a run's final item is followed by a gap
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |=> !rsp_valid_ff)
      else $error("item directly after the final item of a run");
   // wrap and rank error never come from the same command
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_wrapped_ff && rsp_rank_error_ff))
      else $error("wrap and rank error flagged together");
`endif

endmodule
`default_nettype wire

// File: hdl/cun_ctrl.sv
// Controller: sequences table fill, command decode, next scan, unrank walk and result emission.
`timescale 1ns / 1ps
`default_nettype none
module cun_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [cun_pkg::CMD_W-1:0]   req_cmd,
   output      logic                        busy,
   input  wire cun_pkg::cun_stat_type       st,
   output      cun_pkg::cun_cmd_type        cmd
);
   import cun_pkg::*;

   localparam logic [3:0] S_FILL   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_NXSCAN = 4'd2;
   localparam logic [3:0] S_NXFILL = 4'd3;
   localparam logic [3:0] S_URCHKA = 4'd4;
   localparam logic [3:0] S_URCHKB = 4'd5;
   localparam logic [3:0] S_URA    = 4'd6;
   localparam logic [3:0] S_URB    = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;

   logic [3:0] state_ff, state_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (st.fill_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               case (req_cmd)
                  CMD_FIRST: begin
                     cmd.load_first = 1'b1;
                     state_in       = S_EMIT;
                  end
                  CMD_NEXT:   state_in = S_NXSCAN;
                  CMD_UNRANK: state_in = S_URCHKA;
                  default:    state_in = S_EMIT;
               endcase
            end
         end
         S_NXSCAN: begin
            cmd.nx_scan = 1'b1;
            if (st.idx_zero)    state_in = S_EMIT;
            else if (st.nx_hit) state_in = S_NXFILL;
         end
         S_NXFILL: begin
            if (st.idx_at_k) state_in = S_EMIT;
            else cmd.nx_fill = 1'b1;
         end
         S_URCHKA: begin
            cmd.ur_chk_addr = 1'b1;
            state_in        = S_URCHKB;
         end
         S_URCHKB: begin
            cmd.ur_chk = 1'b1;
            state_in   = st.ram_ge ? S_EMIT : S_URA;
         end
         S_URA: begin
            cmd.ur_addr = 1'b1;
            if (st.j_lt_rem)     state_in = S_URB;
            else if (st.ur_last) state_in = S_EMIT;
         end
         S_URB: begin
            cmd.ur_cmp = 1'b1;
            state_in   = (!st.ram_ge && st.ur_last) ? S_EMIT : S_URA;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (st.emit_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register, fill sweep runs first after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   // an accepted item keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accepting an item");
   // the final emit returns the block to idle
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && st.emit_last) |=> !busy)
      else $error("still busy after the final item of a run");
`endif

endmodule
`default_nettype wire

// File: hdl/combination_unrank_and_next.sv
// Top level: lexicographic k-of-n combination unrank / successor with serial element output.
//
//  channel   ports                                   handshake
//  request   start, busy, req_cmd, req_rank          taken when start && !busy
//  result    rsp_valid, rsp_position, rsp_element,   one item per cycle, no back-pressure
//            rsp_last, rsp_wrapped, rsp_rank_error
//  config    csr_wr_en, csr_index, csr_wdata         written when csr_wr_en high
//
//  After reset a table fill pass writes the TABLE_DIM*TABLE_DIM binomial table entries
//  (625 by default); busy stays high through it. Config writes are taken during the pass.
//  First loads the combination 1..k and emits it; an unused command emits the stored one.
//  Next scans back for the rightmost element that can step up, refills the positions after
//  it (or wraps to the first combination), then emits. Unrank checks the rank against the
//  table entry C(n,k), then walks the positions with one binomial table read and compare
//  per candidate, placing an element at the end of its row without a compare. Items leave
//  one per cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module combination_unrank_and_next #(
   parameter int MAX_SET   = 24,
   parameter int TABLE_DIM = 25
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire logic [cun_pkg::CMD_W-1:0]       req_cmd,
   input  wire logic [cun_pkg::RANK_W-1:0]      req_rank,
   output      logic                            rsp_valid,
   output      logic [cun_pkg::FIELD_W-1:0]     rsp_position,
   output      logic [cun_pkg::FIELD_W-1:0]     rsp_element,
   output      logic                            rsp_last,
   output      logic                            rsp_wrapped,
   output      logic                            rsp_rank_error,
   input  wire logic                            csr_wr_en,
   input  wire logic [cun_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cun_pkg::FIELD_W-1:0]     csr_wdata
);
   import cun_pkg::*;

   cun_cmd_type  cmd;
   cun_stat_type st;

   cun_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .busy    (busy),
      .st      (st),
      .cmd     (cmd)
   );

   cun_datapath #(
      .MAX_SET   (MAX_SET),
      .TABLE_DIM (TABLE_DIM)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_rank       (req_rank),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_position   (rsp_position),
      .rsp_element    (rsp_element),
      .rsp_last       (rsp_last),
      .rsp_wrapped    (rsp_wrapped),
      .rsp_rank_error (rsp_rank_error)
   );

endmodule
`default_nettype wire
